>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, action and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 13;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   localparam cfg_type CFG_RESET = 13'd4096;

   localparam action_type ACT_ALLOC = 2'd0;
   localparam action_type ACT_FREE  = 2'd1;
   localparam action_type ACT_QUERY = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FAIL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/bba_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one action and its bit index per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
   import bba_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   index_type  bit_index;

   modport source (output valid, output action, output bit_index, input ready);
   modport sink   (input valid, input action, input bit_index, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying status, allocated index and queried bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_rsp_if;
   import bba_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   index_type  index;
   logic       bit_value;

   modport source (output valid, output status, output index, output bit_value,
                   input ready);
   modport sink   (input valid, input status, input index, input bit_value,
                   output ready);

endinterface

`default_nettype wire

>>> hw/rtl/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit allocator over a used-block bitmap held in a word memory.
// ----------------------------------------------------------------------------
// After reset the map memory is cleared one word per cycle, with req ready
// low. Then one request is handled at a time. An allocate reads the map one
// word per cycle through a single priority encoder until it finds the first
// free bit. A free or query divides the index, reads the map word, then
// updates it (free) or returns the bit (query); an out-of-range or unknown
// action goes straight to the response. csr_wr_data sets the number of map
// bits in use; write it only while no request is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core #(
   parameter int MAP_BITS  = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   bba_req_if.sink          req_chan,
   bba_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  bba_pkg::cfg_type csr_wr_data
);
   import bba_pkg::*;

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAP_WORDS + 1);
   localparam int BW        = $clog2(WORD_BITS);
   localparam int LW        = $clog2(MAP_BITS + 1);
   localparam int CW        = (LW > CFG_W) ? LW : CFG_W;
   localparam int DIV_S     = INDEX_W + BW;
   localparam int DIV_M     = (2 ** DIV_S) / WORD_BITS + 1;
   localparam int DIV_MW    = $clog2(DIV_M + 1);
   localparam int PROD_W    = INDEX_W + DIV_MW;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_LOOKUP = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   logic [2:0]      state_ff, state_in;
   cfg_type         csr_ff, csr_in;
   logic [AW-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic            chk_vld_ff, chk_vld_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]   chk_ptr_ff, chk_ptr_in;
   logic [CW-1:0]   base_ff, base_in;
   action_type      act_ff, act_in;
   index_type       idx_ff, idx_in;
   logic [AW-1:0]   q_ff, q_in;
   logic [BW-1:0]   pos_ff, pos_in;
   status_type      res_status_ff, res_status_in;
   index_type       res_index_ff, res_index_in;
   logic            res_value_ff, res_value_in;
   status_type      rsp_status_ff, rsp_status_in;
   index_type       rsp_index_ff, rsp_index_in;
   logic            rsp_value_ff, rsp_value_in;

   logic [CW-1:0]        limit;
   logic                 enc_found;
   logic [BW-1:0]        enc_pos;
   logic [CW:0]          cand;
   logic [BW-1:0]        mask_pos;
   logic [WORD_BITS-1:0] bit_mask;
   logic [PROD_W-1:0]    prod;

   bba_first_clear #(
      .WORD_BITS(WORD_BITS)
   ) u_first_clear (
      .word  (rd_data_ff),
      .found (enc_found),
      .pos   (enc_pos)
   );

   assign limit    = (CW'(csr_ff) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(csr_ff);
   assign cand     = {1'b0, base_ff} + (CW + 1)'(enc_pos);
   assign mask_pos = (state_ff == S_SCAN) ? enc_pos : pos_ff;
   assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << mask_pos;
   assign prod     = PROD_W'(idx_ff) * PROD_W'(DIV_M);
   assign rd_addr  = (state_ff == S_SCAN) ? issue_cnt_ff[AW-1:0] : q_ff;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.index     = rsp_index_ff;
   assign rsp_chan.bit_value = rsp_value_ff;

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_wr_en ? csr_wr_data : csr_ff;
      clr_ptr_in    = clr_ptr_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_vld_in    = chk_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      chk_ptr_in    = chk_ptr_ff;
      base_in       = base_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      q_in          = q_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_wa        = q_ff;
      mem_wd        = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in       = req_chan.action;
               idx_in       = req_chan.bit_index;
               res_index_in = '0;
               res_value_in = 1'b0;
               unique case (req_chan.action)
                  ACT_ALLOC: begin
                     issue_cnt_in = '0;
                     chk_vld_in   = 1'b0;
                     chk_ptr_in   = '0;
                     base_in      = '0;
                     state_in     = S_SCAN;
                  end
                  ACT_FREE, ACT_QUERY: begin
                     if (CW'(req_chan.bit_index) < limit) begin
                        state_in = S_LOOKUP;
                     end else begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_cnt_ff < CNT_W'(MAP_WORDS)) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               chk_vld_in   = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               priority if (base_ff >= limit) begin
                  res_status_in = ST_FAIL;
                  state_in      = S_DONE;
               end else if (enc_found) begin
                  if (cand < {1'b0, limit}) begin
                     mem_we        = 1'b1;
                     mem_wa        = chk_ptr_ff;
                     mem_wd        = rd_data_ff | bit_mask;
                     res_status_in = ST_OK;
                     res_index_in  = cand[INDEX_W-1:0];
                  end else begin
                     res_status_in = ST_FAIL;
                  end
                  state_in = S_DONE;
               end else if (chk_ptr_ff == AW'(MAP_WORDS - 1)) begin
                  res_status_in = ST_FAIL;
                  state_in      = S_DONE;
               end else begin
                  chk_ptr_in = chk_ptr_ff + AW'(1);
                  base_in    = base_ff + CW'(WORD_BITS);
               end
            end
         end
         S_LOOKUP: begin
            q_in     = AW'(prod >> DIV_S);
            state_in = S_READ;
         end
         S_READ: begin
            pos_in   = BW'(idx_ff - INDEX_W'(q_ff * WORD_BITS));
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (act_ff == ACT_QUERY) begin
               res_status_in = ST_OK;
               res_value_in  = rd_data_ff[pos_ff];
            end else if (!rd_data_ff[pos_ff]) begin
               res_status_in = ST_FAIL;
            end else begin
               mem_we        = 1'b1;
               mem_wa        = q_ff;
               mem_wd        = rd_data_ff & ~bit_mask;
               res_status_in = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         csr_ff       <= CFG_RESET;
         clr_ptr_ff   <= '0;
         issue_cnt_ff <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         clr_ptr_ff   <= clr_ptr_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ptr_ff    <= chk_ptr_in;
      base_ff       <= base_in;
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      q_ff          <= q_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/bba_first_clear.sv
// ----------------------------------------------------------------------------
// First clear bit finder
// Priority encoder giving the lowest zero bit of one map word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_first_clear #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0]         word,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] pos
);

   localparam int BW = $clog2(WORD_BITS);

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            found = 1'b1;
            pos   = BW'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level assertions on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bba_pkg::status_type rsp_status,
   input bba_pkg::index_type  rsp_index,
   input logic                rsp_bit_value
);
   import bba_pkg::*;

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready high right after a request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_index) && $stable(rsp_bit_value))
      else $error("stalled response changed");

   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_index == '0) && !rsp_bit_value)
      else $error("failed response carries index or bit value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_FAIL) ||
         (rsp_status == ST_RANGE))
      else $error("response status code undefined");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_index     (rsp_chan.index),
   .rsp_bit_value (rsp_chan.bit_value)
);

`default_nettype wire

>>> dv/bitmap_block_allocator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator core testbench
// Sends allocate, free, query and unused-action requests under several
// bit-count settings. Random stalls are applied on both channels. Each
// response is checked against a bit-level copy of the used-block map kept
// alongside the core.
// ----------------------------------------------------------------------------

module bitmap_block_allocator_core_test;
   import bba_pkg::*;

   localparam int MAP_BITS = 4096;
   localparam action_type ACT_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 136;

   typedef struct packed {
      action_type action;
      index_type  bit_index;
   } alloc_req_type;

   typedef struct packed {
      status_type status;
      index_type  index;
      logic       bit_value;
   } alloc_rsp_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_wr_en;
   cfg_type csr_wr_data;

   bba_req_if req_bus();
   bba_rsp_if rsp_bus();

   bitmap_block_allocator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bit [MAP_BITS-1:0] used_map = '0;
   cfg_type           bits_in_use = CFG_RESET;
   alloc_req_type     pending_reqs[$];
   alloc_rsp_type     expected_rsps[$];
   alloc_req_type     next_req;
   alloc_rsp_type     want_rsp;
   int                req_gap = 0;
   int                rsp_gap = 0;
   int                req_idle_pct = 10;
   int                rsp_idle_pct = 10;
   int                failures = 0;
   int                settings_done = 0;
   int                action_count[4] = '{default: 0};
   int                status_count[4] = '{default: 0};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Next response for one request; updates the map copy.
   function automatic alloc_rsp_type apply_request(alloc_req_type r);
      alloc_rsp_type res;
      int unsigned   lim;
      res.status    = ST_RANGE;
      res.index     = '0;
      res.bit_value = 1'b0;
      lim = (bits_in_use > MAP_BITS) ? MAP_BITS : bits_in_use;
      case (r.action)
         ACT_ALLOC: begin
            res.status = ST_FAIL;
            for (int unsigned i = 0; i < lim && res.status != ST_OK; i++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  res.status  = ST_OK;
                  res.index   = index_type'(i);
               end
            end
         end
         ACT_FREE: begin
            if (r.bit_index >= lim)
               res.status = ST_RANGE;
            else if (!used_map[r.bit_index])
               res.status = ST_FAIL;
            else begin
               used_map[r.bit_index] = 1'b0;
               res.status = ST_OK;
            end
         end
         ACT_QUERY: begin
            if (r.bit_index < lim) begin
               res.status    = ST_OK;
               res.bit_value = used_map[r.bit_index];
            end
         end
         default: res.status = ST_RANGE;
      endcase
      return res;
   endfunction

   task automatic push_req(input action_type a, input index_type idx);
      alloc_req_type r;
      r.action    = a;
      r.bit_index = idx;
      pending_reqs.push_back(r);
      action_count[a]++;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_bits_in_use(input cfg_type v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bits_in_use = v;
      settings_done++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            next_req.action    = req_bus.action;
            next_req.bit_index = req_bus.bit_index;
            expected_rsps.push_back(apply_request(next_req));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.action    <= next_req.action;
               req_bus.bit_index <= next_req.bit_index;
               if ($urandom_range(0, 99) < req_idle_pct)
                  req_gap = $urandom_range(1, 16);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            status_count[rsp_bus.status]++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: status %0d index %0d",
                      rsp_bus.status, rsp_bus.index);
               failures++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_bus.status !== want_rsp.status) begin
                  $error("status: expected %0d, got %0d", want_rsp.status, rsp_bus.status);
                  failures++;
               end
               if (rsp_bus.index !== want_rsp.index) begin
                  $error("index: expected %0d, got %0d", want_rsp.index, rsp_bus.index);
                  failures++;
               end
               if (rsp_bus.bit_value !== want_rsp.bit_value) begin
                  $error("bit_value: expected %0d, got %0d",
                         want_rsp.bit_value, rsp_bus.bit_value);
                  failures++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < rsp_idle_pct)
               rsp_gap = $urandom_range(1, 16);
         end
      end
   end

   initial begin
      int unsigned lim, span, pick, left, chunk;
      cfg_type     setting;
      index_type   idx;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = CFG_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty map, first fit, double free, unused action
      push_req(ACT_QUERY, 12'd0);
      push_req(ACT_QUERY, 12'hFFF);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_FREE, 12'd1);
      push_req(ACT_FREE, 12'd1);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_QUERY, 12'd1);
      push_req(ACT_FREE, 12'hFFF);
      push_req(ACT_UNUSED, 12'hFFF);
      wait_drained();
      // lowered limit: full map and out-of-range accesses
      write_bits_in_use(cfg_type'(3));
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_QUERY, 12'd2);
      push_req(ACT_QUERY, 12'd3);
      push_req(ACT_FREE, 12'd3);
      wait_drained();
      write_bits_in_use('0);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_QUERY, 12'd0);
      wait_drained();
      // limit above map size saturates; bits set earlier are still there
      write_bits_in_use('1);
      push_req(ACT_QUERY, 12'hFFF);
      push_req(ACT_ALLOC, 12'd0);
      push_req(ACT_FREE, 12'd0);
      push_req(ACT_QUERY, 12'd2);
      push_req(ACT_ALLOC, 12'hFFF);
      push_req(ACT_UNUSED, 12'd0);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: setting = CFG_RESET;
            1: setting = cfg_type'($urandom_range(1, 40));
            2: setting = cfg_type'(64);
            3: setting = '1;
            4: setting = cfg_type'(65);
            5: setting = cfg_type'($urandom_range(100, 600));
            6: setting = cfg_type'(1);
            7: setting = cfg_type'($urandom_range(0, 8191));
            default: setting = cfg_type'($urandom_range(20, 200));
         endcase
         write_bits_in_use(setting);
         if (p == PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end
         lim  = (bits_in_use > MAP_BITS) ? MAP_BITS : bits_in_use;
         left = PHASE_ITEMS;
         while (left > 0) begin
            chunk = $urandom_range(1, 30);
            if (chunk > left)
               chunk = left;
            left -= chunk;
            for (int unsigned k = 0; k < chunk; k++) begin
               span = $countones(used_map) + 8;
               if (span > lim)
                  span = lim;
               idx  = (span == 0) ? index_type'($urandom_range(0, 4095))
                                  : index_type'($urandom_range(0, span - 1));
               pick = $urandom_range(0, 99);
               if (pick < 42)
                  push_req(ACT_ALLOC, index_type'($urandom_range(0, 4095)));
               else if (pick < 66)
                  push_req(ACT_FREE, idx);
               else if (pick < 84) begin
                  if ($urandom_range(0, 5) == 0 && lim > 0)
                     idx = index_type'(lim - 1 + $urandom_range(0, 2));
                  push_req(ACT_QUERY, idx);
               end else
                  push_req(action_type'($urandom_range(0, 3)),
                           index_type'($urandom_range(0, 4095)));
            end
            if ($urandom_range(0, 3) == 0)
               wait_drained();
            else
               while (pending_reqs.size() > 3)
                  @(posedge clock);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         failures++;
      end
      $display("Sent %0d allocate, %0d free, %0d query, %0d unused-action requests",
               action_count[ACT_ALLOC], action_count[ACT_FREE], action_count[ACT_QUERY],
               action_count[ACT_UNUSED]);
      $display("over %0d bit-count settings; responses: %0d ok, %0d full or already free, %0d out of range",
               settings_done, status_count[ST_OK], status_count[ST_FAIL],
               status_count[ST_RANGE]);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_req_if.sv
hw/rtl/bba_rsp_if.sv
hw/rtl/bba_first_clear.sv
hw/rtl/bitmap_block_allocator_core.sv
hw/rtl/bba_checker.sv
dv/bitmap_block_allocator_core_test.sv
